/* hw/rtl/ep0c_pkg.sv */
// ----------------------------------------------------------------------------
// Endpoint-0 control transfer package
// Shared types, command codes and phase codes of the control transfer core.
// ----------------------------------------------------------------------------
package ep0c_pkg;

    // Request codes of an input beat.
    localparam logic [2:0] REQ_SEND     = 3'd0;
    localparam logic [2:0] REQ_RECEIVE  = 3'd1;
    localparam logic [2:0] REQ_ACK      = 3'd2;
    localparam logic [2:0] REQ_STALL    = 3'd3;
    localparam logic [2:0] REQ_IN_DONE  = 3'd4;
    localparam logic [2:0] REQ_OUT_DONE = 3'd5;

    // Endpoint status commands.
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_NAK   = 2'd1;
    localparam logic [1:0] CMD_VALID = 2'd2;
    localparam logic [1:0] CMD_STALL = 2'd3;

    // Control transfer phases.
    localparam logic [2:0] PH_WAIT_SETUP = 3'd0;
    localparam logic [2:0] PH_IN_DATA    = 3'd1;
    localparam logic [2:0] PH_LAST_IN    = 3'd2;
    localparam logic [2:0] PH_WAIT_SOUT  = 3'd3;
    localparam logic [2:0] PH_OUT_DATA   = 3'd4;
    localparam logic [2:0] PH_WAIT_SIN   = 3'd5;
    localparam logic [2:0] PH_STALLED    = 3'd6;

    // Event codes.
    localparam logic [1:0] EV_OK        = 2'd0;
    localparam logic [1:0] EV_WRITE_END = 2'd1;
    localparam logic [1:0] EV_ADDRESSED = 2'd2;

    // Packet size code after reset (64 bytes).
    localparam logic [1:0] PKT_SIZE_RESET = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] data_len;
        logic [15:0] host_len;
        logic [9:0]  rx_count;
        logic        is_addr_assign;
        logic [6:0]  new_address;
    } t_req;

    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] rx_cmd;
        logic [1:0] tx_cmd;
        logic [6:0] tx_count;
        logic [9:0] copy_len;
        logic [1:0] event_code;
        logic       address_write;
        logic [6:0] address_out;
    } t_rsp;

    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] bytes_left;
        logic        zlp_pending;
    } t_state;

endpackage

/* hw/rtl/ep0c_req_if.sv */
// ----------------------------------------------------------------------------
// Endpoint-0 request channel
// Valid/ready channel that carries one command or completion event a beat.
// ----------------------------------------------------------------------------
interface ep0c_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [15:0] data_len;
    logic [15:0] host_len;
    logic [9:0]  rx_count;
    logic        is_addr_assign;
    logic [6:0]  new_address;

    modport source (
        output valid, req_type, data_len, host_len, rx_count, is_addr_assign,
               new_address,
        input  ready
    );

    modport sink (
        input  valid, req_type, data_len, host_len, rx_count, is_addr_assign,
               new_address,
        output ready
    );
endinterface

/* hw/rtl/ep0c_rsp_if.sv */
// ----------------------------------------------------------------------------
// Endpoint-0 response channel
// Valid/ready channel that carries the endpoint commands of one step a beat.
// ----------------------------------------------------------------------------
interface ep0c_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] phase;
    logic [1:0] rx_cmd;
    logic [1:0] tx_cmd;
    logic [6:0] tx_count;
    logic [9:0] copy_len;
    logic [1:0] event_code;
    logic       address_write;
    logic [6:0] address_out;

    modport source (
        output valid, phase, rx_cmd, tx_cmd, tx_count, copy_len, event_code,
               address_write, address_out,
        input  ready
    );

    modport sink (
        input  valid, phase, rx_cmd, tx_cmd, tx_count, copy_len, event_code,
               address_write, address_out,
        output ready
    );
endinterface

/* hw/rtl/ep0c_step.sv */
// ----------------------------------------------------------------------------
// Endpoint-0 control step logic
// Works out the next transfer state and the endpoint commands for one beat.
// ----------------------------------------------------------------------------
module ep0c_step
    import ep0c_pkg::*;
(
    input  logic [1:0] i_pkt_size,
    input  t_req       i_req,
    input  t_state     i_state,
    output t_state     o_state,
    output t_rsp       o_rsp
);

    logic [6:0]  w_mps;
    logic [15:0] w_mps16;
    logic [15:0] w_mask;
    logic [15:0] w_len;
    logic [15:0] w_chunk;
    logic [15:0] w_rx16;
    logic [15:0] w_rx_len;
    logic [15:0] w_left_after;
    logic        w_stall;

    // Max packet size and the chunk arithmetic shared by the branches.
    always_comb begin
        w_mps    = 7'd8 << i_pkt_size;
        w_mps16  = {9'd0, w_mps};
        w_mask   = w_mps16 - 16'd1;
        w_len    = (i_req.data_len >= i_req.host_len) ? i_req.host_len : i_req.data_len;
        w_rx16   = {6'd0, i_req.rx_count};
        w_rx_len = (w_rx16 > i_state.bytes_left) ? i_state.bytes_left : w_rx16;
        w_left_after = i_state.bytes_left - w_rx_len;
    end

    // Main step.
    always_comb begin
        o_state = i_state;
        o_rsp   = '0;
        w_stall = 1'b0;
        w_chunk = '0;

        case (i_req.req_type)
            REQ_SEND: begin
                // Any stale trailing-packet flag is dropped by a new send.
                o_state.zlp_pending = (i_req.data_len < i_req.host_len)
                                      && (w_len != 16'd0)
                                      && ((w_len & w_mask) == 16'd0);
                if (w_len <= w_mps16) begin
                    w_chunk       = w_len;
                    o_state.phase = PH_LAST_IN;
                end else begin
                    w_chunk       = w_mps16;
                    o_state.phase = PH_IN_DATA;
                end
                o_state.bytes_left = w_len - w_chunk;
                o_rsp.copy_len     = w_chunk[9:0];
                o_rsp.tx_count     = w_chunk[6:0];
                o_rsp.rx_cmd       = CMD_NAK;
                o_rsp.tx_cmd       = CMD_VALID;
            end
            REQ_RECEIVE: begin
                o_state.bytes_left = i_req.data_len;
                o_state.phase      = PH_OUT_DATA;
                o_rsp.rx_cmd       = CMD_VALID;
            end
            REQ_ACK: begin
                o_state.phase = PH_WAIT_SIN;
                o_rsp.rx_cmd  = CMD_NAK;
                o_rsp.tx_cmd  = CMD_VALID;
            end
            REQ_STALL: begin
                w_stall = 1'b1;
            end
            REQ_IN_DONE: begin
                if (i_state.phase inside {PH_IN_DATA, PH_LAST_IN}) begin
                    if (i_state.bytes_left == 16'd0 && i_state.phase == PH_LAST_IN) begin
                        if (i_state.zlp_pending) begin
                            // Trailing zero-length packet.
                            o_state.zlp_pending = 1'b0;
                            o_rsp.tx_cmd        = CMD_VALID;
                        end else begin
                            o_state.phase = PH_WAIT_SOUT;
                            o_rsp.rx_cmd  = CMD_VALID;
                        end
                    end else begin
                        o_state.phase = (i_state.bytes_left <= w_mps16) ? PH_LAST_IN
                                                                         : PH_IN_DATA;
                        w_chunk = (i_state.bytes_left < w_mps16) ? i_state.bytes_left
                                                                  : w_mps16;
                        o_state.bytes_left = i_state.bytes_left - w_chunk;
                        o_rsp.copy_len     = w_chunk[9:0];
                        o_rsp.tx_count     = w_chunk[6:0];
                        o_rsp.tx_cmd       = CMD_VALID;
                    end
                end else if (i_state.phase == PH_WAIT_SIN) begin
                    o_state.phase = PH_WAIT_SETUP;
                    if (i_req.is_addr_assign) begin
                        o_rsp.address_write = 1'b1;
                        o_rsp.address_out   = i_req.new_address;
                        o_rsp.event_code    = EV_ADDRESSED;
                    end else begin
                        o_rsp.event_code = EV_WRITE_END;
                    end
                end else begin
                    w_stall = 1'b1;
                end
            end
            REQ_OUT_DONE: begin
                if (i_state.phase == PH_OUT_DATA) begin
                    // Overlong packets are clipped to what is still expected.
                    o_rsp.copy_len     = w_rx_len[9:0];
                    o_state.bytes_left = w_left_after;
                    if (w_left_after == 16'd0) begin
                        o_state.phase = PH_WAIT_SIN;
                        o_rsp.tx_cmd  = CMD_VALID;
                    end else begin
                        o_rsp.rx_cmd = CMD_VALID;
                    end
                end else if (i_state.phase == PH_WAIT_SOUT) begin
                    o_state.phase = PH_WAIT_SETUP;
                end else begin
                    w_stall = 1'b1;
                end
            end
            default: begin
                // Unknown requests leave the state alone.
            end
        endcase

        if (w_stall) begin
            o_state.phase = PH_STALLED;
            o_rsp.rx_cmd  = CMD_STALL;
            o_rsp.tx_cmd  = CMD_STALL;
        end

        o_rsp.phase = o_state.phase;
    end

endmodule

/* hw/rtl/usb_ep0_control_transfer_fsm_core.sv */
// ----------------------------------------------------------------------------
// Endpoint-0 control transfer core
// Sequences the data and status stages of USB endpoint-0 control transfers.
// ----------------------------------------------------------------------------
// Each request beat is captured in an input register, worked through one
// step of logic once the output register is free to load, and its response
// is loaded into the output register at the end of that cycle. The transfer
// state is updated in the same cycle as the step, so the core takes one
// request beat every cycle while the response side keeps taking beats; a
// stalled response holds the input register and then the request channel.
// The user must write the max packet size register through the configuration
// port only while no request is in flight; the core does not enforce this.
module usb_ep0_control_transfer_fsm_core
    import ep0c_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_wdata,
    ep0c_req_if.sink          i_req,
    ep0c_rsp_if.source        o_rsp
);

    logic [1:0] r_pkt_size;
    logic       r_in_valid;
    t_req       r_in;
    logic       r_out_valid;
    t_rsp       r_out;
    t_state     r_state;

    logic       w_advance;
    logic       w_fire;
    logic       w_in_take;
    t_req       w_req;
    t_state     n_state;
    t_rsp       n_out;

    // Handshake: the step fires when the output register is free to load.
    assign w_advance   = !r_out_valid || o_rsp.ready;
    assign w_fire      = r_in_valid && w_advance;
    assign i_req.ready = !r_in_valid || w_advance;
    assign w_in_take   = i_req.valid && i_req.ready;

    assign w_req.req_type       = i_req.req_type;
    assign w_req.data_len       = i_req.data_len;
    assign w_req.host_len       = i_req.host_len;
    assign w_req.rx_count       = i_req.rx_count;
    assign w_req.is_addr_assign = i_req.is_addr_assign;
    assign w_req.new_address    = i_req.new_address;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_size <= PKT_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_pkt_size <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= w_req;
        end
    end

    // One step of the transfer sequencer.
    ep0c_step u_step (
        .i_pkt_size (r_pkt_size),
        .i_req      (r_in),
        .i_state    (r_state),
        .o_state    (n_state),
        .o_rsp      (n_out)
    );

    // Transfer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_WAIT_SETUP, bytes_left: 16'd0, zlp_pending: 1'b0};
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.phase         = r_out.phase;
    assign o_rsp.rx_cmd        = r_out.rx_cmd;
    assign o_rsp.tx_cmd        = r_out.tx_cmd;
    assign o_rsp.tx_count      = r_out.tx_count;
    assign o_rsp.copy_len      = r_out.copy_len;
    assign o_rsp.event_code    = r_out.event_code;
    assign o_rsp.address_write = r_out.address_write;
    assign o_rsp.address_out   = r_out.address_out;

    // A byte count is only armed together with a valid transmit command.
    a_tx_count_needs_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.tx_count != 7'd0) |-> (r_out.tx_cmd == CMD_VALID))
        else $error("tx_count armed without a valid tx command");

    // The address write only closes a status stage back to waiting for setup.
    a_addr_write_event : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.address_write) |->
            (r_out.event_code == EV_ADDRESSED && r_out.phase == PH_WAIT_SETUP))
        else $error("address write without its event or phase");

    // A held request beat is never dropped while the response side stalls.
    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid)
        else $error("request beat lost during stall");

    // The reported phase is the phase the state has moved to.
    a_phase_tracks_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_out.phase == r_state.phase))
        else $error("reported phase differs from state");

endmodule
